### rtl/lrucs_pkg.sv
// Shared types and constants for the LRU cache reference simulator.
// Holds the controller state enum, the command/status structs and helpers.
// No dependencies.
package lrucs_pkg;

  // Width of config counts (ways, sets), the set pointer and set bounds
  localparam int CNT_W  = 5;
  localparam int PTR_W  = 4;
  localparam int SPAN_W = 9;
  localparam int LINE_OUT_W = 4;
  localparam int MISS_W = 32;
  localparam int IN_W   = 16;

  // Configuration register indexes
  localparam logic REG_WAYS = 1'b0;
  localparam logic REG_SETS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch input item, clear scan flags
    logic reduce;    // subtract set count from the set pointer
    logic base;      // latch the set bounds
    logic scan;      // issue the next line read
    logic commit;    // apply hit or placement
    logic load;      // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ptr_ge;     // set pointer not yet below the set count
    logic last_issue; // the read being issued is the last line
  } sts_t;

  // Map a raw count register to 1..16
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(16)) begin
      r = CNT_W'(16);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/lru_cache_reference_simulator.sv
// Top level of the LRU cache reference simulator.
// Depends on lrucs_pkg; instantiates lrucs_ctrl and lrucs_dp.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     ref_value
//   output    out_valid / out_ready   was_hit, line_touched, miss_total
//   config    cfg_we                  cfg_index, cfg_data
//
// An item passes through accept, set base, one read per line through the
// single read port of the line memory, drain, commit and output load. A
// set pointer left beyond a reduced set count adds repeated subtractions
// of the set count before the set base. Reset clears all valid bits at
// once; no clearing pass. A stalled output holds the next item at the load.
module lru_cache_reference_simulator #(
  parameter int LINES    = 16,
  parameter int TAG_BITS = 16,
  parameter int AGE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lrucs_pkg::CNT_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrucs_pkg::IN_W-1:0]       ref_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             was_hit,
  output logic [lrucs_pkg::LINE_OUT_W-1:0] line_touched,
  output logic [lrucs_pkg::MISS_W-1:0]     miss_total
);
  import lrucs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrucs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrucs_dp #(
    .LINES    (LINES),
    .TAG_BITS (TAG_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ref_value    (ref_value),
    .cmd          (cmd),
    .sts          (sts),
    .was_hit      (was_hit),
    .line_touched (line_touched),
    .miss_total   (miss_total)
  );

endmodule

### rtl/lrucs_ctrl.sv
// Controller state machine for the LRU cache reference simulator.
// Depends on lrucs_pkg; drives the datapath by cmd_t and reads sts_t.
module lrucs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lrucs_pkg::sts_t sts,
  output lrucs_pkg::cmd_t cmd
);
  import lrucs_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.ptr_ge) begin
          cmd.reduce = 1'b1;
        end else begin
          cmd.base = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/lrucs_dp.sv
// Datapath of the LRU cache reference simulator: line memory, valid bits,
// scan pipeline, set pointer, miss counter and result registers.
// Depends on lrucs_pkg; controlled by lrucs_ctrl.
module lrucs_dp #(
  parameter int LINES    = 16,
  parameter int TAG_BITS = 16,
  parameter int AGE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lrucs_pkg::CNT_W-1:0]      cfg_data,
  input  logic [lrucs_pkg::IN_W-1:0]       ref_value,
  input  lrucs_pkg::cmd_t                  cmd,
  output lrucs_pkg::sts_t                  sts,
  output logic                             was_hit,
  output logic [lrucs_pkg::LINE_OUT_W-1:0] line_touched,
  output logic [lrucs_pkg::MISS_W-1:0]     miss_total
);
  import lrucs_pkg::*;

  localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WORD_W = TAG_BITS + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Configuration and item state
  logic [CNT_W-1:0]    ways, sets;
  logic [CNT_W-1:0]    nways, nsets;
  logic [PTR_W-1:0]    set_pointer;
  logic [MISS_W-1:0]   miss_count;
  logic [TAG_BITS-1:0] tag;
  logic [SPAN_W-1:0]   set_first, set_end;

  // Line storage: tag and age per line, valid bits in flops
  logic [WORD_W-1:0]   mem [LINES];
  logic [WORD_W-1:0]   rdata;
  logic [LINES-1:0]    line_valid;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // Scan pipeline
  logic [IDX_W-1:0]    scan_idx;
  logic                proc_vld;
  logic [IDX_W-1:0]    proc_idx;

  // Scan findings
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                found_empty;
  logic [IDX_W-1:0]    empty_idx;
  logic                any;
  logic [IDX_W-1:0]    victim_idx;
  logic [AGE_BITS-1:0] best;

  // Item result held until loaded
  logic                fin_hit;
  logic [IDX_W-1:0]    fin_line;

  // Line under inspection
  logic [TAG_BITS-1:0] rtag;
  logic [AGE_BITS-1:0] rage, aged;
  logic                pv;
  logic                in_set;
  logic [SPAN_W-1:0]   proc_span;
  logic [CNT_W-1:0]    ptr_inc;

  assign nways = clamp_count(ways);
  assign nsets = clamp_count(sets);

  assign rtag = rdata[WORD_W-1:AGE_BITS];
  assign rage = rdata[AGE_BITS-1:0];
  assign pv   = line_valid[proc_idx];
  assign aged = (pv && rage != AGE_MAX) ? rage + AGE_BITS'(1) : rage;
  assign proc_span = SPAN_W'(proc_idx);
  assign in_set = (proc_span >= set_first) && (proc_span < set_end);
  assign ptr_inc = CNT_W'(set_pointer) + CNT_W'(1);

  assign sts.ptr_ge     = CNT_W'(set_pointer) >= nsets;
  assign sts.last_issue = scan_idx == IDX_W'(LINES - 1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ways <= CNT_W'(4);
      sets <= CNT_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAYS: ways <= cfg_data;
        REG_SETS: sets <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory write select: scan writeback or commit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_idx;
    mem_wdata = {rtag, aged};
    if (cmd.commit) begin
      mem_wdata = {tag, AGE_BITS'(0)};
      if (hit) begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx;
      end else if (found_empty) begin
        mem_we    = 1'b1;
        mem_waddr = empty_idx;
      end else if (any) begin
        mem_we    = 1'b1;
        mem_waddr = victim_idx;
      end
    end else if (proc_vld && pv) begin
      mem_we = 1'b1;
    end
  end

  // Line memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.scan) begin
      rdata <= mem[scan_idx];
    end
  end

  // Control state: valid bits, pointer, counter, scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid  <= '0;
      set_pointer <= '0;
      miss_count  <= '0;
      proc_vld    <= 1'b0;
      scan_idx    <= '0;
    end else begin
      proc_vld <= cmd.scan;
      if (cmd.capture) begin
        scan_idx <= '0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.reduce) begin
        set_pointer <= PTR_W'(CNT_W'(set_pointer) - nsets);
      end
      if (cmd.commit) begin
        set_pointer <= (ptr_inc >= nsets) ? '0 : PTR_W'(ptr_inc);
        if (!hit) begin
          if (miss_count != '1) begin
            miss_count <= miss_count + MISS_W'(1);
          end
          if (found_empty) begin
            line_valid[empty_idx] <= 1'b1;
          end
        end
      end
    end
  end

  // Item payload and scan findings
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag         <= TAG_BITS'(ref_value);
      hit         <= 1'b0;
      found_empty <= 1'b0;
      any         <= 1'b0;
    end
    if (cmd.base) begin
      set_first <= SPAN_W'(set_pointer) * SPAN_W'(nways);
      set_end   <= SPAN_W'(set_pointer) * SPAN_W'(nways) + SPAN_W'(nways);
    end
    if (cmd.scan) begin
      proc_idx <= scan_idx;
    end
    // Inspect the line read last cycle
    if (proc_vld) begin
      if (pv && rtag == tag && !hit) begin
        hit     <= 1'b1;
        hit_idx <= proc_idx;
      end
      if (in_set) begin
        if (!pv && !found_empty) begin
          found_empty <= 1'b1;
          empty_idx   <= proc_idx;
        end
        if (pv && (!any || aged >= best)) begin
          any        <= 1'b1;
          best       <= aged;
          victim_idx <= proc_idx;
        end
      end
    end
    // Resolve the line touched
    if (cmd.commit) begin
      fin_hit <= hit;
      if (hit) begin
        fin_line <= hit_idx;
      end else if (found_empty) begin
        fin_line <= empty_idx;
      end else if (any) begin
        fin_line <= victim_idx;
      end else begin
        fin_line <= '0;
      end
    end
    // Output register
    if (cmd.load) begin
      was_hit      <= fin_hit;
      line_touched <= LINE_OUT_W'(fin_line);
      miss_total   <= miss_count;
    end
  end

endmodule

### rtl/lrucs_checker.sv
// Port-level checks for the LRU cache reference simulator.
// Depends on lrucs_pkg; bound to lru_cache_reference_simulator below.
module lrucs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             was_hit,
  input logic [lrucs_pkg::LINE_OUT_W-1:0] line_touched,
  input logic [lrucs_pkg::MISS_W-1:0]     miss_total
);
  import lrucs_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(was_hit)
      && $stable(line_touched) && $stable(miss_total))
    else $error("output item changed while stalled");

  // No result shows right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // An accepted item keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // A new result frees the input side
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while input still blocked");

endmodule

bind lru_cache_reference_simulator lrucs_checker u_chk (.*);

### tb/lru_cache_reference_simulator_test.sv
// Testbench for lru_cache_reference_simulator: directed and random reference traces.
// A built-in LRU predictor checks every result. Depends on lrucs_pkg and the RTL top.
module lru_cache_reference_simulator_test;

  localparam int LINES = 16;
  localparam int SETTLE_CYCLES = 40;  // worst item latency plus margin

  typedef struct {
    logic                                 hit;
    logic [lrucs_pkg::LINE_OUT_W-1:0]     line;
    logic [lrucs_pkg::MISS_W-1:0]         misses;
  } lookup_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = lrucs_pkg::REG_WAYS;
  logic [lrucs_pkg::CNT_W-1:0]      cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [lrucs_pkg::IN_W-1:0]       ref_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             was_hit;
  logic [lrucs_pkg::LINE_OUT_W-1:0] line_touched;
  logic [lrucs_pkg::MISS_W-1:0]     miss_total;

  // Predictor copy of the cache state and geometry
  logic [lrucs_pkg::CNT_W-1:0]  pred_ways = 5'd4;
  logic [lrucs_pkg::CNT_W-1:0]  pred_sets = 5'd4;
  logic [lrucs_pkg::IN_W-1:0]   pred_tag [LINES];
  logic                         pred_valid [LINES];
  logic [15:0]                  pred_age [LINES];
  logic [lrucs_pkg::PTR_W-1:0]  pred_ptr = '0;
  logic [lrucs_pkg::MISS_W-1:0] pred_misses = '0;

  lookup_t results_due [$];

  int  error_count = 0;
  int  refs_sent = 0;
  int  hits_seen = 0;
  int  geometries = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stall = 1'b1;
  int  hold_cycles = 0;

  lru_cache_reference_simulator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ref_value    (ref_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .was_hit      (was_hit),
    .line_touched (line_touched),
    .miss_total   (miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      pred_tag[i]   = '0;
      pred_valid[i] = 1'b0;
      pred_age[i]   = '0;
    end
  end

  // Map a raw count register onto 1..16
  function automatic int unsigned fit_count(input logic [lrucs_pkg::CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 16) return 16;
    return 32'(raw);
  endfunction

  // Age all valid lines, look up the value, place it on a miss, queue the result
  task automatic predict_ref(input logic [lrucs_pkg::IN_W-1:0] v);
    lookup_t     res;
    int unsigned nw, ns, cur, first, last, victim;
    logic [15:0] oldest;
    bit          placed, any;
    nw = fit_count(pred_ways);
    ns = fit_count(pred_sets);
    cur = pred_ptr % ns;
    res.hit = 1'b0;
    res.line = '0;
    placed = 1'b0;
    any = 1'b0;
    victim = 0;
    oldest = '0;
    for (int i = 0; i < LINES; i++)
      if (pred_valid[i] && pred_age[i] != 16'hFFFF) pred_age[i]++;
    for (int i = 0; i < LINES; i++) begin
      if (pred_valid[i] && pred_tag[i] == v) begin
        res.hit = 1'b1;
        res.line = i[3:0];
        pred_age[i] = '0;
        break;
      end
    end
    if (!res.hit) begin
      if (pred_misses != 32'hFFFF_FFFF) pred_misses++;
      first = cur * nw;
      last = first + nw;
      if (last > LINES) last = LINES;
      for (int i = first; i < last; i++) begin
        if (!pred_valid[i]) begin
          pred_valid[i] = 1'b1;
          pred_tag[i] = v;
          pred_age[i] = '0;
          res.line = i[3:0];
          placed = 1'b1;
          break;
        end
      end
      // Full set: evict the oldest line, highest index on a tie
      if (!placed) begin
        for (int i = first; i < last; i++) begin
          if (!any || pred_age[i] >= oldest) begin
            oldest = pred_age[i];
            victim = i;
            any = 1'b1;
          end
        end
        if (any) begin
          pred_tag[victim] = v;
          pred_age[victim] = '0;
          res.line = victim[3:0];
        end
      end
    end
    pred_ptr = (cur + 1 >= ns) ? '0 : lrucs_pkg::PTR_W'(cur + 1);
    res.misses = pred_misses;
    if (res.hit) hits_seen++;
    results_due.push_back(res);
  endtask

  // Offer one item, with an optional idle burst first; valid stays up afterwards
  task automatic send_ref(input logic [lrucs_pkg::IN_W-1:0] v);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    ref_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_ref(v);
    refs_sent++;
  endtask

  // Drop valid and wait until the block has delivered everything and gone idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both geometry registers while idle
  task automatic set_geometry(input logic [lrucs_pkg::CNT_W-1:0] w,
                              input logic [lrucs_pkg::CNT_W-1:0] s);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= lrucs_pkg::REG_WAYS;
    cfg_data  <= w;
    @(posedge clk);
    pred_ways = w;
    cfg_index <= lrucs_pkg::REG_SETS;
    cfg_data  <= s;
    @(posedge clk);
    pred_sets = s;
    cfg_we <= 1'b0;
    @(posedge clk);
    geometries++;
  endtask

  // Draw a value: mostly from a small working set, sometimes anything
  function automatic logic [15:0] pick_ref(input logic [15:0] base, input int pool);
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return base + 16'($urandom_range(0, pool - 1));
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : rx_drive
    int n;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_stall && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result hit=%0b line=%0d misses=%0d",
                 $time, was_hit, line_touched, miss_total);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (was_hit !== want.hit) begin
          $display("%0t: was_hit expected %0b actual %0b", $time, want.hit, was_hit);
          error_count++;
        end
        if (line_touched !== want.line) begin
          $display("%0t: line_touched expected %0d actual %0d",
                   $time, want.line, line_touched);
          error_count++;
        end
        if (miss_total !== want.misses) begin
          $display("%0t: miss_total expected %0d actual %0d",
                   $time, want.misses, miss_total);
          error_count++;
        end
      end
    end
  end

  // Reset geometry: field extremes, a hit and a fill
  task automatic test_reset_geometry();
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'h0000);
    send_ref(16'hAAAA);
    send_ref(16'h5555);
    send_ref(16'hFFFF);
  endtask

  // Zero and oversized counts, sets past the last line, sets with no line
  task automatic test_count_clamping();
    set_geometry(5'd0, 5'd0);
    send_ref(16'h1234);
    send_ref(16'h1234);
    send_ref(16'h4321);
    set_geometry(5'd31, 5'd17);
    send_ref(16'h0F0F);
    send_ref(16'hF0F0);
    send_ref(16'h0F0F);
    send_ref(16'h7777);
  endtask

  // Advance the set pointer, then shrink the set count under it
  task automatic test_pointer_reduction();
    set_geometry(5'd2, 5'd8);
    for (int i = 0; i < 5; i++) send_ref(16'h8100 + 16'(i));
    set_geometry(5'd2, 5'd3);
    for (int i = 0; i < 4; i++) send_ref(16'h8200 + 16'(i));
    send_ref(16'h8100);
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_output_backpressure();
    logic [15:0] base;
    set_geometry(5'd4, 5'd2);
    base = 16'($urandom());
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_ref(pick_ref(base, 12));
  endtask

  // Let every result come back before the next burst
  task automatic test_sender_pause();
    logic [15:0] base;
    base = 16'($urandom());
    for (int i = 0; i < 10; i++) send_ref(pick_ref(base, 8));
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    for (int i = 0; i < 10; i++) send_ref(pick_ref(base, 8));
  endtask

  // Random traces across a spread of geometries
  task automatic test_random_geometries();
    int          way_list [13] = '{4, 1, 16, 1, 2, 8, 3, 16, 0, 20, 5, 31, 7};
    int          set_list [13] = '{4, 1, 1, 16, 8, 2, 5, 16, 5, 3, 0, 31, 2};
    logic [15:0] base;
    int          pool;
    for (int p = 0; p < 13; p++) begin
      set_geometry(5'(way_list[p]), 5'(set_list[p]));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      rx_stall = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) begin
          base = 16'($urandom());
          pool = $urandom_range(2, 40);
        end
        send_ref(pick_ref(base, pool));
      end
    end
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_steady_stream();
    logic [15:0] base;
    set_geometry(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    tx_gaps  = 1'b0;
    rx_stall = 1'b0;
    base = 16'($urandom());
    for (int i = 0; i < 150; i++) send_ref(pick_ref(base, 20));
  endtask

  initial begin : main_seq
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_count_clamping();
    test_pointer_reduction();
    test_output_backpressure();
    test_sender_pause();
    test_random_geometries();
    test_steady_stream();
    settle();
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      error_count++;
    end
    $display("Sent %0d references over %0d geometry settings: %0d hits, %0d misses.",
             refs_sent, geometries, hits_seen, pred_misses);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Global watchdog
  initial begin : watchdog
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
